// File: design/u2a_pkg.sv
// Shared types, constants and helpers for the unsigned to ASCII digit converter.
package u2a_pkg;

    // Width of the converted value; bits above it are ignored
    localparam int VALUE_WIDTH = 64;
    localparam int BIT_CNT_W   = $clog2(VALUE_WIDTH + 1);

    // Digit buffer: 20 nibbles cover any 64-bit decimal value
    localparam int MAX_DIGITS  = 20;
    localparam int DIG_W       = 4 * MAX_DIGITS;
    localparam int CNT_W       = 5;

    // Queue between converter and emitter
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QFILL_W     = $clog2(QUEUE_DEPTH + 1);

    // ASCII anchors
    localparam logic [6:0] CHAR_ZERO = 7'h30;
    localparam logic [6:0] CHAR_A    = 7'h41;

    // One converted number: digits left aligned, plus its digit count
    typedef struct packed {
        logic [DIG_W-1:0] digits;
        logic [CNT_W-1:0] count;
    } digit_rec_t;

    // Nibble to ASCII, '0'-'9' or 'A'-'F'
    function automatic logic [6:0] nibble_to_ascii(input logic [3:0] d);
        logic [6:0] c;
        if (d < 4'd10) begin
            c = CHAR_ZERO + {3'b000, d};
        end else begin
            c = CHAR_A + {3'b000, d} - 7'd10;
        end
        return c;
    endfunction

endpackage

// File: design/u2a_front.sv
// Front end: accepts a word, converts to BCD or hex nibbles, strips leading zeros.
module u2a_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [63:0]         s_value,
    input  logic                s_hex_mode,
    output logic                push_valid,
    output u2a_pkg::digit_rec_t push_rec,
    input  logic                q_full
);
    import u2a_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CONV = 2'd1;
    localparam logic [1:0] ST_SCAN = 2'd2;
    localparam logic [1:0] ST_PUSH = 2'd3;

    logic [1:0]             state_reg, state_next;
    logic [VALUE_WIDTH-1:0] val_reg, val_next;
    logic [DIG_W-1:0]       dig_reg, dig_next;
    logic [BIT_CNT_W-1:0]   bit_cnt_reg, bit_cnt_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic [DIG_W-1:0]       dig_adj;

    // Double dabble correction: add 3 to every BCD digit above 4
    function automatic logic [DIG_W-1:0] add3(input logic [DIG_W-1:0] b);
        logic [DIG_W-1:0] r;
        r = b;
        for (int i = 0; i < MAX_DIGITS; i++) begin
            if (b[4*i +: 4] > 4'd4) begin
                r[4*i +: 4] = b[4*i +: 4] + 4'd3;
            end
        end
        return r;
    endfunction

    assign dig_adj    = add3(dig_reg);
    assign s_ready    = (state_reg == ST_IDLE);
    assign push_valid = (state_reg == ST_PUSH);
    assign push_rec   = '{digits: dig_reg, count: cnt_reg};

    // Sequencer: load, shift-add-3 per bit (decimal only), scan off leading zeros, hand off
    always_comb begin
        state_next   = state_reg;
        val_next     = val_reg;
        dig_next     = dig_reg;
        bit_cnt_next = bit_cnt_reg;
        cnt_next     = cnt_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    val_next     = s_value[VALUE_WIDTH-1:0];
                    cnt_next     = CNT_W'(MAX_DIGITS);
                    bit_cnt_next = BIT_CNT_W'(VALUE_WIDTH);
                    if (s_hex_mode) begin
                        dig_next   = DIG_W'(s_value[VALUE_WIDTH-1:0]);
                        state_next = ST_SCAN;
                    end else begin
                        dig_next   = '0;
                        state_next = ST_CONV;
                    end
                end
            end
            ST_CONV: begin
                dig_next     = {dig_adj[DIG_W-2:0], val_reg[VALUE_WIDTH-1]};
                val_next     = {val_reg[VALUE_WIDTH-2:0], 1'b0};
                bit_cnt_next = bit_cnt_reg - BIT_CNT_W'(1);
                if (bit_cnt_reg == BIT_CNT_W'(1)) begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (dig_reg[DIG_W-1 -: 4] == 4'd0 && cnt_reg > CNT_W'(1)) begin
                    dig_next = {dig_reg[DIG_W-5:0], 4'd0};
                    cnt_next = cnt_reg - CNT_W'(1);
                end else begin
                    state_next = ST_PUSH;
                end
            end
            ST_PUSH: begin
                if (!q_full) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        val_reg     <= val_next;
        dig_reg     <= dig_next;
        bit_cnt_reg <= bit_cnt_next;
        cnt_reg     <= cnt_next;
    end

endmodule

// File: design/u2a_queue.sv
// Small FIFO of converted numbers between front end and emitter.
module u2a_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  u2a_pkg::digit_rec_t push_rec,
    input  logic                pop,
    output u2a_pkg::digit_rec_t head_rec,
    output logic                full,
    output logic                empty
);
    import u2a_pkg::*;

    digit_rec_t        q_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [QFILL_W-1:0] fill_reg;

    assign full     = (fill_reg == QFILL_W'(QUEUE_DEPTH));
    assign empty    = (fill_reg == '0);
    assign head_rec = q_mem[rd_ptr_reg];

    function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
        return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_W'(1);
    endfunction

    // Storage
    always_ff @(posedge aclk) begin
        if (push && !full) begin
            q_mem[wr_ptr_reg] <= push_rec;
        end
    end

    // Pointers and fill level
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            if (push && !full) begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (pop && !empty) begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            if ((push && !full) && !(pop && !empty)) begin
                fill_reg <= fill_reg + QFILL_W'(1);
            end else if (!(push && !full) && (pop && !empty)) begin
                fill_reg <= fill_reg - QFILL_W'(1);
            end
        end
    end

endmodule

// File: design/u2a_back.sv
// Back end: emits one ASCII character per word, most significant digit first.
module u2a_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  u2a_pkg::digit_rec_t head_rec,
    input  logic                q_empty,
    output logic                q_pop,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [6:0]          m_digit_char,
    output logic                m_last_digit,
    output logic [4:0]          m_digit_count
);
    import u2a_pkg::*;

    logic             busy_reg;
    logic [DIG_W-1:0] dig_reg;
    logic [CNT_W-1:0] count_reg, left_reg;
    logic             last;

    assign last          = (left_reg == CNT_W'(1));
    assign m_valid       = busy_reg;
    assign m_digit_char  = nibble_to_ascii(dig_reg[DIG_W-1 -: 4]);
    assign m_last_digit  = last;
    assign m_digit_count = count_reg;

    // Load the next number when idle or as the final character leaves
    assign q_pop = !q_empty && (!busy_reg || (m_ready && last));

    // Busy flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else if (q_pop) begin
            busy_reg <= 1'b1;
        end else if (m_ready && last) begin
            busy_reg <= 1'b0;
        end
    end

    // Character shifter
    always_ff @(posedge aclk) begin
        if (q_pop) begin
            dig_reg   <= head_rec.digits;
            count_reg <= head_rec.count;
            left_reg  <= head_rec.count;
        end else if (busy_reg && m_ready) begin
            dig_reg  <= {dig_reg[DIG_W-5:0], 4'd0};
            left_reg <= left_reg - CNT_W'(1);
        end
    end

endmodule

// File: design/unsigned_to_ascii_digits_unit.sv
// Top level: unsigned value to ASCII decimal or hex digit stream.
//
// Input channel (s_): one word is a 64-bit unsigned value and a radix select
// (s_hex_mode 0 = decimal, 1 = uppercase hex). Output channel (m_): one word
// per character, most significant first, no leading zeros; a zero value gives
// a single '0'. Each word carries the character, a last-character flag and
// the total character count (1 to 20).
// Path to the first character: a decimal number runs through the double dabble
// shift-add-3 loop, the leading-zero scan, the hand-off into the queue and the
// load in the emitter. Hex skips the loop and always scans off at least four
// zero nibbles.
// Overlap: the front end takes one number at a time and is ready again the
// cycle after its hand-off; characters leave at one per cycle while m_ready
// is high, while the front end already converts the next number.
// A two-entry queue separates front end and emitter, so a stalled receiver
// only holds up the front end once the queue is full; m_ words hold steady
// while m_ready is low.
// Reset (aresetn low, synchronous) empties the queue and returns both sides
// to idle; any number in flight is dropped.
module unsigned_to_ascii_digits_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [63:0] s_value,
    input  logic        s_hex_mode,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [6:0]  m_digit_char,
    output logic        m_last_digit,
    output logic [4:0]  m_digit_count
);
    import u2a_pkg::*;

    logic       push_valid;
    digit_rec_t push_rec;
    digit_rec_t head_rec;
    logic       q_full, q_empty, q_pop;

    u2a_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_value    (s_value),
        .s_hex_mode (s_hex_mode),
        .push_valid (push_valid),
        .push_rec   (push_rec),
        .q_full     (q_full)
    );

    u2a_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push_valid),
        .push_rec (push_rec),
        .pop      (q_pop),
        .head_rec (head_rec),
        .full     (q_full),
        .empty    (q_empty)
    );

    u2a_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .head_rec      (head_rec),
        .q_empty       (q_empty),
        .q_pop         (q_pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_digit_char  (m_digit_char),
        .m_last_digit  (m_last_digit),
        .m_digit_count (m_digit_count)
    );

endmodule
